FILE: src/cafs_pkg.sv
`default_nettype none
package cafs_pkg;

  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int EV_W   = 3;
  localparam int IDX_W  = 1;
  localparam int BEAT_W = 3;

  localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RX      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PAYLOAD = 2'd2;

  localparam logic [IDX_W-1:0] REG_IMAGE_LENGTH = 1'b0;
  localparam logic [IDX_W-1:0] REG_CHUNK_SIZE   = 1'b1;

  localparam logic [BYTE_W-1:0] ACK_CODE = 8'h06;

  localparam logic [BYTE_W-1:0] MAGIC [4] = '{8'hDE, 8'hAD, 8'hBE, 8'hEF};

  localparam logic [BEAT_W-1:0] HDR_LAST_BEAT = 3'd7;

  localparam int IMAGE_LENGTH_RESET = 25088;
  localparam int CHUNK_SIZE_RESET   = 1024;

  typedef enum logic [EV_W-1:0] {
    EV_HDR         = 3'd0,
    EV_HDR_LAST    = 3'd1,
    EV_SENT        = 3'd2,
    EV_CHUNK_END   = 3'd3,
    EV_DONE        = 3'd4,
    EV_FIRST_ABORT = 3'd5,
    EV_CHUNK_ABORT = 3'd6,
    EV_REJECT      = 3'd7
  } event_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FIRST = 2'd1,
    PH_SEND  = 2'd2,
    PH_WAIT  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    DESC_NONE = 2'd0,
    DESC_ONE  = 2'd1,
    DESC_HDR  = 2'd2
  } desc_kind_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] rx_byte;
    logic              rx_ok;
    logic [BYTE_W-1:0] payload_byte;
  } in_item_t;

  typedef struct packed {
    desc_kind_t        kind;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    event_t            event_res;
  } desc_t;

endpackage
`default_nettype wire

FILE: src/chunked_ack_frame_sender_top.sv
`default_nettype none
// channel   | valid      | ready      | payload
// ----------+------------+------------+---------------------------------------------
// input     | in_valid   | in_ready   | in_command, in_rx_byte, in_rx_ok, in_payload_byte
// result    | out_valid  | out_ready  | out_tx_valid, out_tx_byte, out_last,
//           |            |            | out_event_res, out_bytes_done
// config    | cfg_wen    | -          | cfg_index, cfg_wdata
//
// one item per cycle unless stalled: input register, decode logic, result register
// a start command yields eight header results, one per cycle while out_ready is high,
// and holds the input stage until the last header byte is taken;
// a silent ack leaves the input register without using the result register
// reset is synchronous active low; it clears the phase, counters and result valid state
// out_ready low holds the result; the input register still fills and passes silent acks
module chunked_ack_frame_sender_top #(
  parameter int LENGTH_BITS = 20,
  parameter int CHUNK_BITS  = 13,
  localparam int CFG_W = (LENGTH_BITS > CHUNK_BITS) ? LENGTH_BITS : CHUNK_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cafs_pkg::CMD_W-1:0]    in_command,
  input  logic [cafs_pkg::BYTE_W-1:0]   in_rx_byte,
  input  logic                          in_rx_ok,
  input  logic [cafs_pkg::BYTE_W-1:0]   in_payload_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_tx_valid,
  output logic [cafs_pkg::BYTE_W-1:0]   out_tx_byte,
  output logic                          out_last,
  output logic [cafs_pkg::EV_W-1:0]     out_event_res,
  output logic [LENGTH_BITS-1:0]        out_bytes_done,
  input  logic                          cfg_wen,
  input  logic [cafs_pkg::IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]              cfg_wdata
);
  import cafs_pkg::*;

  in_item_t               in_item;
  in_item_t               s1_item;
  logic                   s1_valid;
  logic                   s1_consume;
  logic                   load_ok;
  logic                   d_load;
  desc_t                  d_desc;
  logic [LENGTH_BITS-1:0] d_done;
  logic [LENGTH_BITS-1:0] d_len;

  assign in_item.command      = in_command;
  assign in_item.rx_byte      = in_rx_byte;
  assign in_item.rx_ok        = in_rx_ok;
  assign in_item.payload_byte = in_payload_byte;

  cafs_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item),
    .s1_consume (s1_consume)
  );

  cafs_ctrl #(
    .LENGTH_BITS (LENGTH_BITS),
    .CHUNK_BITS  (CHUNK_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item),
    .s1_consume (s1_consume),
    .load_ok    (load_ok),
    .d_load     (d_load),
    .d_desc     (d_desc),
    .d_done     (d_done),
    .d_len      (d_len)
  );

  cafs_out_seq #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_out_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .d_load         (d_load),
    .d_desc         (d_desc),
    .d_done         (d_done),
    .d_len          (d_len),
    .load_ok        (load_ok),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tx_valid   (out_tx_valid),
    .out_tx_byte    (out_tx_byte),
    .out_last       (out_last),
    .out_event_res  (out_event_res),
    .out_bytes_done (out_bytes_done)
  );

endmodule
`default_nettype wire

FILE: src/cafs_in_reg.sv
`default_nettype none
module cafs_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cafs_pkg::in_item_t in_item,
  output logic               s1_valid,
  output cafs_pkg::in_item_t s1_item,
  input  logic               s1_consume
);
  import cafs_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  assign in_ready = !valid_r || s1_consume;
  assign s1_valid = valid_r;
  assign s1_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

FILE: src/cafs_ctrl.sv
`default_nettype none
module cafs_ctrl #(
  parameter int LENGTH_BITS = 20,
  parameter int CHUNK_BITS  = 13,
  localparam int CFG_W = (LENGTH_BITS > CHUNK_BITS) ? LENGTH_BITS : CHUNK_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wen,
  input  logic [cafs_pkg::IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]               cfg_wdata,
  input  logic                           s1_valid,
  input  cafs_pkg::in_item_t             s1_item,
  output logic                           s1_consume,
  input  logic                           load_ok,
  output logic                           d_load,
  output cafs_pkg::desc_t                d_desc,
  output logic [LENGTH_BITS-1:0]         d_done,
  output logic [LENGTH_BITS-1:0]         d_len
);
  import cafs_pkg::*;

  localparam int W = CFG_W + 1;

  logic [LENGTH_BITS-1:0] image_length_r;
  logic [CHUNK_BITS-1:0]  chunk_size_r;

  phase_t                 phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] acked_r, acked_nxt;
  logic [CHUNK_BITS-1:0]  fill_r, fill_nxt;
  logic [CHUNK_BITS-1:0]  target_r, target_nxt;

  logic                   good;
  logic [W-1:0]           sum_w;
  logic [LENGTH_BITS-1:0] acked_new;
  logic [LENGTH_BITS-1:0] rem;
  logic [CHUNK_BITS-1:0]  cs;
  logic [W-1:0]           min_w;
  logic [CHUNK_BITS-1:0]  fill_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_length_r <= LENGTH_BITS'(IMAGE_LENGTH_RESET);
      chunk_size_r   <= CHUNK_BITS'(CHUNK_SIZE_RESET);
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_IMAGE_LENGTH: image_length_r <= cfg_wdata[LENGTH_BITS-1:0];
        REG_CHUNK_SIZE:   chunk_size_r   <= cfg_wdata[CHUNK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ack arithmetic and next chunk size
  always_comb begin
    good      = s1_item.rx_ok && (s1_item.rx_byte == ACK_CODE);
    sum_w     = W'(acked_r) + W'(target_r);
    acked_new = (phase_r == PH_WAIT) ? sum_w[LENGTH_BITS-1:0] : acked_r;
    rem       = image_length_r - acked_new;
    cs        = (chunk_size_r == '0) ? CHUNK_BITS'(1) : chunk_size_r;
    min_w     = (W'(cs) < W'(rem)) ? W'(cs) : W'(rem);
    fill_inc  = fill_r + CHUNK_BITS'(1);
  end

  always_comb begin
    phase_nxt        = phase_r;
    acked_nxt        = acked_r;
    fill_nxt         = fill_r;
    target_nxt       = target_r;
    d_desc.kind      = DESC_ONE;
    d_desc.tx_valid  = 1'b0;
    d_desc.tx_byte   = '0;
    d_desc.event_res = EV_REJECT;
    d_done           = '0;
    case (s1_item.command)
      CMD_START: begin
        if (phase_r == PH_IDLE) begin
          d_desc.kind      = DESC_HDR;
          d_desc.tx_valid  = 1'b1;
          d_desc.event_res = EV_HDR;
          acked_nxt        = '0;
          fill_nxt         = '0;
          target_nxt       = '0;
          phase_nxt        = PH_FIRST;
        end
      end
      CMD_RX: begin
        if (phase_r inside {PH_FIRST, PH_WAIT}) begin
          if (!good) begin
            d_desc.event_res = (phase_r == PH_FIRST) ? EV_FIRST_ABORT : EV_CHUNK_ABORT;
            d_done           = acked_r;
            phase_nxt        = PH_IDLE;
          end else begin
            acked_nxt = acked_new;
            if (acked_new >= image_length_r) begin
              d_desc.event_res = EV_DONE;
              d_done           = acked_new;
              phase_nxt        = PH_IDLE;
            end else begin
              // good ack opens the next chunk silently
              d_desc.kind = DESC_NONE;
              target_nxt  = min_w[CHUNK_BITS-1:0];
              fill_nxt    = '0;
              phase_nxt   = PH_SEND;
            end
          end
        end
      end
      CMD_PAYLOAD: begin
        if (phase_r == PH_SEND) begin
          d_desc.tx_valid = 1'b1;
          d_desc.tx_byte  = s1_item.payload_byte;
          fill_nxt        = fill_inc;
          if (fill_inc >= target_r) begin
            d_desc.event_res = EV_CHUNK_END;
            phase_nxt        = PH_WAIT;
          end else begin
            d_desc.event_res = EV_SENT;
          end
        end
      end
      default: ;
    endcase
  end

  assign d_len      = image_length_r;
  assign s1_consume = s1_valid && ((d_desc.kind == DESC_NONE) || load_ok);
  assign d_load     = s1_valid && (d_desc.kind != DESC_NONE) && load_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      acked_r  <= '0;
      fill_r   <= '0;
      target_r <= '0;
    end else if (s1_consume) begin
      phase_r  <= phase_nxt;
      acked_r  <= acked_nxt;
      fill_r   <= fill_nxt;
      target_r <= target_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/cafs_out_seq.sv
`default_nettype none
module cafs_out_seq #(
  parameter int LENGTH_BITS = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            d_load,
  input  cafs_pkg::desc_t                 d_desc,
  input  logic [LENGTH_BITS-1:0]          d_done,
  input  logic [LENGTH_BITS-1:0]          d_len,
  output logic                            load_ok,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_tx_valid,
  output logic [cafs_pkg::BYTE_W-1:0]     out_tx_byte,
  output logic                            out_last,
  output logic [cafs_pkg::EV_W-1:0]       out_event_res,
  output logic [LENGTH_BITS-1:0]          out_bytes_done
);
  import cafs_pkg::*;

  logic                   busy_r;
  logic                   hdr_r;
  logic [BEAT_W-1:0]      beat_r;
  logic [LENGTH_BITS-1:0] len_r;
  logic                   tx_valid_r;
  logic [BYTE_W-1:0]      tx_byte_r;
  event_t                 event_r;
  logic [LENGTH_BITS-1:0] done_r;

  logic                   final_beat;
  logic [31:0]            len32;
  logic [BYTE_W-1:0]      hdr_byte;

  assign final_beat = !hdr_r || (beat_r == HDR_LAST_BEAT);
  assign load_ok    = !busy_r || (out_ready && final_beat);

  // header: magic bytes then the length little-endian
  assign len32    = 32'(len_r);
  assign hdr_byte = beat_r[2] ? len32[{beat_r[1:0], 3'b000} +: BYTE_W] : MAGIC[beat_r[1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      hdr_r  <= 1'b0;
      beat_r <= '0;
    end else if (d_load) begin
      busy_r <= 1'b1;
      hdr_r  <= (d_desc.kind == DESC_HDR);
      beat_r <= '0;
    end else if (busy_r && out_ready) begin
      if (final_beat) begin
        busy_r <= 1'b0;
      end else begin
        beat_r <= beat_r + BEAT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_load) begin
      len_r      <= d_len;
      tx_valid_r <= d_desc.tx_valid;
      tx_byte_r  <= d_desc.tx_byte;
      event_r    <= d_desc.event_res;
      done_r     <= d_done;
    end
  end

  always_comb begin
    out_valid = busy_r;
    if (hdr_r) begin
      out_tx_valid   = 1'b1;
      out_tx_byte    = hdr_byte;
      out_last       = (beat_r == HDR_LAST_BEAT);
      out_event_res  = (beat_r == HDR_LAST_BEAT) ? EV_HDR_LAST : EV_HDR;
      out_bytes_done = '0;
    end else begin
      out_tx_valid   = tx_valid_r;
      out_tx_byte    = tx_byte_r;
      out_last       = 1'b1;
      out_event_res  = event_r;
      out_bytes_done = done_r;
    end
  end

endmodule
`default_nettype wire

FILE: src/cafs_checker.sv
`default_nettype none
module cafs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_tx_valid,
  input logic [cafs_pkg::BYTE_W-1:0] out_tx_byte,
  input logic                        out_last,
  input logic [cafs_pkg::EV_W-1:0]   out_event_res
);
  import cafs_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tx_byte) && $stable(out_event_res))
    else $error("result changed while stalled");

  // header bytes follow each other with no gap
  a_hdr_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_event_res == EV_HDR) |=> out_valid)
    else $error("gap inside header burst");

  // only the final header byte closes the burst
  a_hdr_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_event_res == EV_HDR) || (out_event_res == EV_HDR_LAST))
      |-> out_tx_valid && (out_last == (out_event_res == EV_HDR_LAST)))
    else $error("header beat flags wrong");

  // status events send nothing on the link
  a_status_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_event_res == EV_REJECT) || (out_event_res == EV_DONE) ||
                  (out_event_res == EV_FIRST_ABORT) || (out_event_res == EV_CHUNK_ABORT))
      |-> !out_tx_valid && out_last)
    else $error("status event drives tx");

endmodule

bind chunked_ack_frame_sender_top cafs_checker u_cafs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_tx_valid  (out_tx_valid),
  .out_tx_byte   (out_tx_byte),
  .out_last      (out_last),
  .out_event_res (out_event_res)
);
`default_nettype wire

FILE: tb/sv/chunked_ack_frame_sender_checker.sv
`default_nettype none
module chunked_ack_frame_sender_checker #(
  parameter int LEN_W = 20,
  parameter int CHK_W = 13,
  parameter int CFG_W = 20
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic [cafs_pkg::CMD_W-1:0]  in_command,
  input  wire logic [cafs_pkg::BYTE_W-1:0] in_rx_byte,
  input  wire logic                        in_rx_ok,
  input  wire logic [cafs_pkg::BYTE_W-1:0] in_payload_byte,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic                        out_tx_valid,
  input  wire logic [cafs_pkg::BYTE_W-1:0] out_tx_byte,
  input  wire logic                        out_last,
  input  wire logic [cafs_pkg::EV_W-1:0]   out_event_res,
  input  wire logic [LEN_W-1:0]            out_bytes_done,
  input  wire logic                        cfg_wen,
  input  wire logic [cafs_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]            cfg_wdata,
  output int                               mismatch_count,
  output int                               results_owed
);
  import cafs_pkg::*;

  typedef struct {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              last;
    event_t            ev;
    logic [LEN_W-1:0]  done;
  } link_result_t;

  link_result_t     owed_q[$];
  int               errs;
  phase_t           link_phase;
  logic [LEN_W-1:0] img_len;
  logic [LEN_W-1:0] acked;
  logic [CHK_W-1:0] chunk_sz;
  logic [CHK_W-1:0] fill;
  logic [CHK_W-1:0] target;

  function automatic link_result_t make_result(logic v, logic [BYTE_W-1:0] b, logic l,
                                               event_t e, logic [LEN_W-1:0] d);
    link_result_t r;
    r.tx_valid = v;
    r.tx_byte  = b;
    r.last     = l;
    r.ev       = e;
    r.done     = d;
    return r;
  endfunction

  task automatic predict_link(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] rxb, logic ok,
                              logic [BYTE_W-1:0] pay);
    logic        ack_good;
    logic [31:0] hdr_len;
    logic [31:0] room;
    logic [CHK_W-1:0] step;
    int i;
    ack_good = ok && (rxb == ACK_CODE);
    if (cmd == CMD_START && link_phase == PH_IDLE) begin
      hdr_len = 32'(img_len);
      for (i = 0; i < 4; i++) owed_q.push_back(make_result(1'b1, MAGIC[i], 1'b0, EV_HDR, '0));
      for (i = 0; i < 4; i++)
        owed_q.push_back(make_result(1'b1, hdr_len[8*i +: 8], i == 3,
                                     (i == 3) ? EV_HDR_LAST : EV_HDR, '0));
      acked      = '0;
      fill       = '0;
      target     = '0;
      link_phase = PH_FIRST;
    end else if (cmd == CMD_RX && (link_phase == PH_FIRST || link_phase == PH_WAIT)) begin
      if (!ack_good) begin
        owed_q.push_back(make_result(1'b0, '0, 1'b1,
          (link_phase == PH_FIRST) ? EV_FIRST_ABORT : EV_CHUNK_ABORT, acked));
        link_phase = PH_IDLE;
      end else begin
        if (link_phase == PH_WAIT) acked = acked + LEN_W'(target);
        if (acked >= img_len) begin
          owed_q.push_back(make_result(1'b0, '0, 1'b1, EV_DONE, acked));
          link_phase = PH_IDLE;
        end else begin
          // a good ack opens the next chunk silently
          room   = 32'(img_len) - 32'(acked);
          step   = (chunk_sz == '0) ? CHK_W'(1) : chunk_sz;
          target = (32'(step) < room) ? step : CHK_W'(room);
          fill   = '0;
          link_phase = PH_SEND;
        end
      end
    end else if (cmd == CMD_PAYLOAD && link_phase == PH_SEND) begin
      fill = fill + CHK_W'(1);
      if (fill >= target) begin
        link_phase = PH_WAIT;
        owed_q.push_back(make_result(1'b1, pay, 1'b1, EV_CHUNK_END, '0));
      end else begin
        owed_q.push_back(make_result(1'b1, pay, 1'b1, EV_SENT, '0));
      end
    end else begin
      owed_q.push_back(make_result(1'b0, '0, 1'b1, EV_REJECT, '0));
    end
  endtask

  task automatic compare_result();
    link_result_t want;
    if (owed_q.size() == 0) begin
      $error("result with nothing owed: event_res %0d tx_byte %0h", out_event_res, out_tx_byte);
      errs++;
    end else begin
      want = owed_q.pop_front();
      if (out_tx_valid !== want.tx_valid) begin
        $error("tx_valid: expected %0d, got %0d", want.tx_valid, out_tx_valid);
        errs++;
      end
      if (out_tx_byte !== want.tx_byte) begin
        $error("tx_byte: expected %0h, got %0h", want.tx_byte, out_tx_byte);
        errs++;
      end
      if (out_last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, out_last);
        errs++;
      end
      if (out_event_res !== want.ev) begin
        $error("event_res: expected %0d, got %0d", want.ev, out_event_res);
        errs++;
      end
      if (out_bytes_done !== want.done) begin
        $error("bytes_done: expected %0d, got %0d", want.done, out_bytes_done);
        errs++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      owed_q.delete();
      link_phase = PH_IDLE;
      img_len    = LEN_W'(IMAGE_LENGTH_RESET);
      chunk_sz   = CHK_W'(CHUNK_SIZE_RESET);
      acked      = '0;
      fill       = '0;
      target     = '0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_IMAGE_LENGTH: img_len = cfg_wdata[LEN_W-1:0];
          REG_CHUNK_SIZE:   chunk_sz = cfg_wdata[CHK_W-1:0];
          default: ;
        endcase
      end
      // results leave before this edge's input is decoded
      if (out_valid && out_ready) compare_result();
      if (in_valid && in_ready) predict_link(in_command, in_rx_byte, in_rx_ok, in_payload_byte);
    end
    results_owed   <= owed_q.size();
    mismatch_count <= errs;
  end

endmodule
`default_nettype wire

FILE: tb/sv/chunked_ack_frame_sender_top_tb.sv
`default_nettype none
module chunked_ack_frame_sender_top_tb;
  import cafs_pkg::*;

  localparam int LEN_W        = 20;
  localparam int CHK_W        = 13;
  localparam int CFG_W        = 20;
  localparam int MAX_CYCLES   = 300000;
  localparam int RANDOM_ITEMS = 370;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [CMD_W-1:0]  in_command;
  logic [BYTE_W-1:0] in_rx_byte;
  logic              in_rx_ok;
  logic [BYTE_W-1:0] in_payload_byte;
  logic              out_valid;
  logic              out_ready;
  logic              out_tx_valid;
  logic [BYTE_W-1:0] out_tx_byte;
  logic              out_last;
  logic [EV_W-1:0]   out_event_res;
  logic [LEN_W-1:0]  out_bytes_done;
  logic              cfg_wen;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;
  int                mismatch_count;
  int                results_owed;

  int items_sent;
  int burst_left;
  int random_goal;
  int cur_len;
  int cur_cs;
  int cycle_cnt;

  chunked_ack_frame_sender_top #(
    .LENGTH_BITS(LEN_W),
    .CHUNK_BITS (CHK_W)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_rx_byte     (in_rx_byte),
    .in_rx_ok       (in_rx_ok),
    .in_payload_byte(in_payload_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tx_valid   (out_tx_valid),
    .out_tx_byte    (out_tx_byte),
    .out_last       (out_last),
    .out_event_res  (out_event_res),
    .out_bytes_done (out_bytes_done),
    .cfg_wen        (cfg_wen),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  chunked_ack_frame_sender_checker #(
    .LEN_W(LEN_W),
    .CHK_W(CHK_W),
    .CFG_W(CFG_W)
  ) frame_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_rx_byte     (in_rx_byte),
    .in_rx_ok       (in_rx_ok),
    .in_payload_byte(in_payload_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tx_valid   (out_tx_valid),
    .out_tx_byte    (out_tx_byte),
    .out_last       (out_last),
    .out_event_res  (out_event_res),
    .out_bytes_done (out_bytes_done),
    .cfg_wen        (cfg_wen),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // offer one item and hold it until its transfer, then maybe leave a gap
  task automatic offer(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] rxb, logic ok,
                       logic [BYTE_W-1:0] pay);
    int gap;
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_rx_byte      <= rxb;
    in_rx_ok        <= ok;
    in_payload_byte <= pay;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic offer_any(logic [CMD_W-1:0] cmd);
    offer(cmd, BYTE_W'($urandom), 1'($urandom), BYTE_W'($urandom));
  endtask

  // an item the current phase refuses
  task automatic offer_noise(logic [CMD_W-1:0] a, logic [CMD_W-1:0] b, logic [CMD_W-1:0] c);
    case ($urandom_range(0, 2))
      0: offer_any(a);
      1: offer_any(b);
      default: offer_any(c);
    endcase
  endtask

  task automatic offer_bad_ack();
    logic [BYTE_W-1:0] rxb;
    rxb = BYTE_W'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      offer(CMD_RX, rxb, 1'b0, BYTE_W'($urandom));
    end else begin
      if (rxb == ACK_CODE) rxb = rxb ^ 8'h80;
      offer(CMD_RX, rxb, 1'b1, BYTE_W'($urandom));
    end
  endtask

  // let every owed result out, then give a silent ack time to drain
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(int len, int cs);
    wait_quiet();
    cfg_wen   <= 1'b1;
    cfg_index <= REG_IMAGE_LENGTH;
    cfg_wdata <= CFG_W'(len);
    @(posedge clk);
    cfg_index <= REG_CHUNK_SIZE;
    cfg_wdata <= CFG_W'(cs);
    @(posedge clk);
    cfg_wen <= 1'b0;
    cur_len = len;
    cur_cs  = cs;
  endtask

  // mostly short images; big lengths only with tiny chunks since transfers get aborted
  task automatic pick_config();
    case ($urandom_range(0, 9))
      6:       set_config($urandom_range(25, 200), $urandom_range(8, 64));
      7:       set_config($urandom_range(0, 30), $urandom_range(4095, 4096));
      8:       set_config(20'hFFFFF, $urandom_range(1, 3));
      9:       set_config(int'(LEN_W'($urandom)), $urandom_range(1, 8));
      default: set_config($urandom_range(0, 24), $urandom_range(0, 6));
    endcase
  endtask

  task automatic run_transfer();
    int acked_sum;
    int chunk_len;
    int sent_here;
    int cap;
    int k;
    cap       = $urandom_range(8, 60);
    acked_sum = 0;
    chunk_len = 0;
    sent_here = 0;
    if ($urandom_range(0, 9) == 0) offer_noise(CMD_RX, CMD_PAYLOAD, CMD_UNUSED);
    offer_any(CMD_START);
    forever begin
      if ($urandom_range(0, 9) == 0) offer_noise(CMD_START, CMD_PAYLOAD, CMD_UNUSED);
      if ($urandom_range(0, 24) == 0 || sent_here > cap || items_sent >= random_goal) begin
        offer_bad_ack();
        return;
      end
      offer(CMD_RX, ACK_CODE, 1'b1, BYTE_W'($urandom));
      acked_sum += chunk_len;
      if (acked_sum >= cur_len) return;
      chunk_len = (cur_cs == 0) ? 1 : cur_cs;
      if (cur_len - acked_sum < chunk_len) chunk_len = cur_len - acked_sum;
      // new settings land mid-transfer; the open chunk keeps its size
      if ($urandom_range(0, 29) == 0) pick_config();
      for (k = 0; k < chunk_len; k++) begin
        if ($urandom_range(0, 11) == 0) offer_noise(CMD_START, CMD_RX, CMD_UNUSED);
        offer_any(CMD_PAYLOAD);
        sent_here++;
      end
    end
  endtask

  // receiver: changing stall patterns plus a few long hold-offs
  initial begin
    int rcv_cycle;
    int mode;
    rcv_cycle = 0;
    mode      = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rcv_cycle % 64 == 0) mode = $urandom_range(0, 3);
      if (rcv_cycle == 300 || rcv_cycle % 1500 == 1499) begin
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
        rcv_cycle += 80;
      end
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom);
        2:       out_ready <= ($urandom_range(0, 4) == 0);
        default: out_ready <= (rcv_cycle % 8 < 5);
      endcase
      @(posedge clk);
      rcv_cycle++;
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < MAX_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[chunked_ack_frame_sender_top] ERROR");
    $finish;
  end

  initial begin
    items_sent = 0;
    burst_left = 0;
    cur_len    = IMAGE_LENGTH_RESET;
    cur_cs     = CHUNK_SIZE_RESET;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_command      <= CMD_START;
    in_rx_byte      <= '0;
    in_rx_ok        <= 1'b0;
    in_payload_byte <= '0;
    cfg_wen         <= 1'b0;
    cfg_index       <= REG_IMAGE_LENGTH;
    cfg_wdata       <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // wrong-state items in idle, header with the reset length, first-ack abort
    offer(CMD_RX, ACK_CODE, 1'b1, BYTE_W'($urandom));
    offer_any(CMD_PAYLOAD);
    offer_any(CMD_UNUSED);
    offer_any(CMD_START);
    offer_any(CMD_START);
    offer_any(CMD_PAYLOAD);
    offer(CMD_RX, ACK_CODE, 1'b0, BYTE_W'($urandom));

    // largest length, chunk size zero acts as one, chunk-ack abort on the second chunk
    set_config(20'hFFFFF, 0);
    offer_any(CMD_START);
    offer(CMD_RX, ACK_CODE, 1'b1, 8'h00);
    offer(CMD_RX, ACK_CODE, 1'b1, 8'hFF);
    offer_any(CMD_START);
    offer(CMD_PAYLOAD, 8'hFF, 1'b1, 8'hFF);
    offer(CMD_PAYLOAD, 8'h00, 1'b0, 8'h55);
    offer(CMD_RX, ACK_CODE, 1'b1, 8'hAA);
    offer(CMD_PAYLOAD, 8'h00, 1'b0, 8'h00);
    offer(CMD_RX, 8'h07, 1'b1, 8'h00);

    // zero length completes at the first ack
    set_config(0, 4096);
    offer_any(CMD_START);
    offer(CMD_RX, ACK_CODE, 1'b1, BYTE_W'($urandom));

    // short last chunk, then completion
    set_config(3, 2);
    offer_any(CMD_START);
    offer(CMD_RX, ACK_CODE, 1'b1, BYTE_W'($urandom));
    offer_any(CMD_PAYLOAD);
    offer_any(CMD_PAYLOAD);
    offer(CMD_RX, ACK_CODE, 1'b1, BYTE_W'($urandom));
    offer_any(CMD_PAYLOAD);
    offer(CMD_RX, ACK_CODE, 1'b1, BYTE_W'($urandom));

    random_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < random_goal) begin
      if ($urandom_range(0, 4) < 2) pick_config();
      if ($urandom_range(0, 19) == 0) wait_quiet();
      run_transfer();
    end

    wait_quiet();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[chunked_ack_frame_sender_top] OK");
    end else begin
      $display("[chunked_ack_frame_sender_top] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
